// ----- src/rmm_pkg.sv -----
package rmm_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int COUNT_BITS     = 16;
  localparam int MEAN_FRAC_BITS = 20;
  localparam int MEAN_BITS      = SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int M2_BITS        = 48;
  localparam int M2_FRAC_BITS   = 8;
  localparam int M4_MID_BITS    = 16;
  localparam int ACC_BITS       = 64;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH = CFG_IDX_BITS'(1);

  localparam logic signed [SAMPLE_BITS-1:0] RANGE_LOW_RST  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] RANGE_HIGH_RST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

endpackage

// ----- src/rmm_if.sv -----
interface rmm_smp_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rmm_pkg::SAMPLE_BITS-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmm_res_if;
  logic                                    valid;
  logic                                    ready;
  logic [rmm_pkg::COUNT_BITS-1:0]          count;
  logic signed [rmm_pkg::MEAN_BITS-1:0]    mean;
  logic [rmm_pkg::M2_BITS-1:0]             sum_sq_dev;
  logic signed [rmm_pkg::ACC_BITS-1:0]     sum_cube_dev;
  logic [rmm_pkg::ACC_BITS-1:0]            sum_quart_dev;
  logic signed [rmm_pkg::SAMPLE_BITS-1:0]  sample_min;
  logic signed [rmm_pkg::SAMPLE_BITS-1:0]  sample_max;
  logic                                    out_of_range;
  logic                                    saturated;

  modport source (output valid, output count, output mean, output sum_sq_dev,
                  output sum_cube_dev, output sum_quart_dev, output sample_min,
                  output sample_max, output out_of_range, output saturated,
                  input ready);
  modport sink (input valid, input count, input mean, input sum_sq_dev,
                input sum_cube_dev, input sum_quart_dev, input sample_min,
                input sample_max, input out_of_range, input saturated,
                output ready);
endinterface

// ----- src/running_moments_minmax_core.sv -----
// Running moments, minimum and maximum of a signed sample stream.
// smp_i carries one sample per transaction; res_o returns one transaction per
// sample with the updated count, mean (Q12.20), central sums M2, M3 and M4,
// minimum, maximum, an out-of-range flag for this sample and a sticky
// saturation flag. The range registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; write them only while the block is idle, which the block itself does not enforce.
// Each sample runs through these steps from acceptance to the next acceptance:
// a restoring divider by the count runs one quotient bit per cycle, a sign
// step fixes the quotient sign, then one 32x32 multiplier evaluates fourteen
// 64x64 products, each as operand load, four partial products, shift and
// clamp, followed by saturating adds and a step that commits the statistics.
// smp_i.ready is high only while no sample is in work. The result waits in
// the output register while the receiver stalls; the next sample is then
// accepted and computed, but its final update holds until the earlier
// result has been taken.
// Reset clears all statistics and flags and restores the full-scale range.
module running_moments_minmax_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  rmm_smp_if.sink                                smp_i,
  rmm_res_if.source                              res_o,
  input  logic                                   cfg_we_i,
  input  logic [rmm_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [rmm_pkg::SAMPLE_BITS-1:0]        cfg_data_i
);

  localparam int SW  = rmm_pkg::SAMPLE_BITS;
  localparam int CW  = rmm_pkg::COUNT_BITS;
  localparam int FB  = rmm_pkg::MEAN_FRAC_BITS;
  localparam int MW  = rmm_pkg::MEAN_BITS;
  localparam int DW  = MW + 1;
  localparam int M2W = rmm_pkg::M2_BITS;
  localparam int W   = rmm_pkg::ACC_BITS;
  localparam int PW  = 2 * W;
  localparam int HW  = W / 2;

  localparam logic [6:0] SH_ZERO = 7'd0;
  localparam logic [6:0] SH_F    = 7'(FB);
  localparam logic [6:0] SH_M2   = 7'(FB + rmm_pkg::M2_FRAC_BITS);
  localparam logic [6:0] SH_C    = 7'(2 * FB - rmm_pkg::M4_MID_BITS);
  localparam logic [6:0] SH_K    = 7'(rmm_pkg::M4_MID_BITS);
  localparam int         SH_T2   = FB - rmm_pkg::M2_FRAC_BITS;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [W-1:0]  M2_MAX  = {{(W-M2W){1'b0}}, {M2W{1'b1}}};
  localparam logic [W-1:0]  S_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  S_MIN   = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SGN  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // Product steps, in the order they run.
  localparam logic [3:0] OP_D_DN    = 4'd0;
  localparam logic [3:0] OP_T1      = 4'd1;
  localparam logic [3:0] OP_DN2     = 4'd2;
  localparam logic [3:0] OP_T1_DN   = 4'd3;
  localparam logic [3:0] OP_A       = 4'd4;
  localparam logic [3:0] OP_DN_M2   = 4'd5;
  localparam logic [3:0] OP_B       = 4'd6;
  localparam logic [3:0] OP_K       = 4'd7;
  localparam logic [3:0] OP_T1_DN2  = 4'd8;
  localparam logic [3:0] OP_C       = 4'd9;
  localparam logic [3:0] OP_DN2_M2  = 4'd10;
  localparam logic [3:0] OP_E       = 4'd11;
  localparam logic [3:0] OP_DN_M3   = 4'd12;
  localparam logic [3:0] OP_F       = 4'd13;

  function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] s;
    logic         ovf;
    s   = a + b;
    ovf = (a[W-1] == b[W-1]) && (s[W-1] != a[W-1]);
    return ovf ? {1'b1, (a[W-1] ? S_MIN : S_MAX)} : {1'b0, s};
  endfunction

  function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] s;
    logic         ovf;
    s   = a - b;
    ovf = (a[W-1] != b[W-1]) && (s[W-1] != a[W-1]);
    return ovf ? {1'b1, (a[W-1] ? S_MIN : S_MAX)} : {1'b0, s};
  endfunction

  logic [2:0]              state_q;
  logic [5:0]              cyc_q;
  logic [3:0]              op_q;

  logic signed [SW-1:0]    range_lo_q, range_hi_q;
  logic [CW-1:0]           cnt_q, n_q;
  logic signed [MW-1:0]    mean_q;
  logic [M2W-1:0]          m2_q;
  logic [W-1:0]            m3_q, m4_q;
  logic signed [SW-1:0]    min_q, max_q, x_q;
  logic                    any_q, sat_q, sat_hit_q, oor_q, oor_pend_q;
  logic                    res_valid_q;

  logic [DW-1:0]           d_q, quo_q;
  logic [CW-1:0]           rem_q;
  logic                    dneg_q;
  logic [W-1:0]            dn_q, p_q, t1_q, dn2_q, a_q, b_q, k_q, c_q, e_q, f_q;
  logic [W-1:0]            ab_q, ce_q, inc4_q;

  logic [W-1:0]            ma_q, mb_q;
  logic                    neg_q;
  logic [6:0]              sh_q;
  logic [PW-1:0]           acc_q;

  logic                    smp_fire, res_fire, done_go;
  logic [DW-1:0]           d_new, d_mag;
  logic                    oor_new;
  logic [CW:0]             rem_sh;
  logic                    rem_ge;
  logic [W-1:0]            opa, opb;
  logic [6:0]              sh_sel;
  logic [HW-1:0]           pa, pb;
  logic [W-1:0]            pprod;
  logic [PW-1:0]           pterm;
  logic [PW-1:0]           shifted;
  logic [W-1:0]            limit, lo_clamp, mres;
  logic                    over;
  logic [W-1:0]            n_ext, m2_ext;
  logic [W:0]              ab_r, ce_r, m3_r, inc4_r, m4_sum;
  logic [W-1:0]            mag4, t1_adj, t2, m2_sum, m4_new;
  logic                    m4_sat;
  logic [M2W-1:0]          m2_new;
  logic                    m2_sat;
  logic [W-1:0]            mean_sum;
  logic signed [SW-1:0]    min_new, max_new;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign smp_fire    = smp_i.valid && smp_i.ready;
  assign res_fire    = res_valid_q && res_o.ready;
  assign done_go     = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);

  // Difference from the mean with the sample lifted to the mean's format.
  assign d_new   = {smp_i.sample[SW-1], smp_i.sample, {FB{1'b0}}} - {mean_q[MW-1], mean_q};
  assign d_mag   = d_new[DW-1] ? (~d_new + DW'(1)) : d_new;
  assign oor_new = (smp_i.sample < range_lo_q) || (smp_i.sample > range_hi_q);

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, n_q};

  assign n_ext  = {{(W-CW){1'b0}}, n_q};
  assign m2_ext = {{(W-M2W){1'b0}}, m2_q};

  always_comb begin
    opa    = '0;
    opb    = '0;
    sh_sel = SH_ZERO;
    case (op_q)
      OP_D_DN:   begin opa = {{(W-DW){d_q[DW-1]}}, d_q}; opb = dn_q; sh_sel = SH_F; end
      OP_T1:     begin opa = p_q; opb = n_ext - W'(1); end
      OP_DN2:    begin opa = dn_q; opb = dn_q; sh_sel = SH_F; end
      OP_T1_DN:  begin opa = t1_q; opb = dn_q; sh_sel = SH_F; end
      OP_A:      begin opa = p_q; opb = n_ext - W'(2); sh_sel = SH_F; end
      OP_DN_M2:  begin opa = dn_q; opb = m2_ext; sh_sel = SH_M2; end
      OP_B:      begin opa = p_q; opb = W'(3); end
      OP_K:      begin opa = n_ext; opb = n_ext - W'(3); end
      OP_T1_DN2: begin opa = t1_q; opb = dn2_q; sh_sel = SH_C; end
      OP_C:      begin opa = p_q; opb = k_q + W'(3); sh_sel = SH_K; end
      OP_DN2_M2: begin opa = dn2_q; opb = m2_ext; sh_sel = SH_M2; end
      OP_E:      begin opa = p_q; opb = W'(6); end
      OP_DN_M3:  begin opa = dn_q; opb = m3_q; sh_sel = SH_F; end
      OP_F:      begin opa = p_q; opb = W'(4); end
      default:   begin opa = '0; opb = '0; sh_sel = SH_ZERO; end
    endcase
  end

  // One 32x32 partial product per cycle, accumulated into the wide product.
  always_comb begin
    pa = cyc_q[1] ? ma_q[W-1:HW] : ma_q[HW-1:0];
    pb = cyc_q[0] ? mb_q[W-1:HW] : mb_q[HW-1:0];
    pprod = pa * pb;
    case (cyc_q[1:0])
      2'd0:    pterm = {{W{1'b0}}, pprod};
      2'd3:    pterm = {pprod, {W{1'b0}}};
      default: pterm = {{HW{1'b0}}, pprod, {HW{1'b0}}};
    endcase
  end

  always_comb begin
    shifted  = acc_q >> sh_q;
    limit    = neg_q ? S_MIN : S_MAX;
    over     = (|shifted[PW-1:W]) || (shifted[W-1:0] > limit);
    lo_clamp = over ? limit : shifted[W-1:0];
    mres     = neg_q ? (~lo_clamp + W'(1)) : lo_clamp;
  end

  assign ab_r   = sat_sub(a_q, b_q);
  assign ce_r   = sat_add(c_q, e_q);
  assign m3_r   = sat_add(m3_q, ab_q);
  assign inc4_r = sat_sub(ce_q, f_q);

  always_comb begin
    mag4   = ~inc4_q + W'(1);
    m4_sum = {1'b0, m4_q} + {1'b0, inc4_q};
    m4_sat = 1'b0;
    if (!inc4_q[W-1]) begin
      m4_sat = m4_sum[W];
      m4_new = m4_sum[W] ? {W{1'b1}} : m4_sum[W-1:0];
    end else begin
      m4_new = (mag4 > m4_q) ? '0 : (m4_q - mag4);
    end
    t1_adj = t1_q + (t1_q[W-1] ? W'((64'd1 << SH_T2) - 64'd1) : '0);
    t2     = W'($signed(t1_adj) >>> SH_T2);
    m2_sum = m2_ext + t2;
    m2_sat = m2_sum > M2_MAX;
    m2_new = m2_sat ? M2_MAX[M2W-1:0] : m2_sum[M2W-1:0];
    mean_sum = {{(W-MW){mean_q[MW-1]}}, mean_q} + dn_q;
    if (!any_q) begin
      min_new = x_q;
      max_new = x_q;
    end else begin
      min_new = (x_q < min_q) ? x_q : min_q;
      max_new = (x_q > max_q) ? x_q : max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo_q <= rmm_pkg::RANGE_LOW_RST;
      range_hi_q <= rmm_pkg::RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rmm_pkg::REG_RANGE_LOW) begin
        range_lo_q <= cfg_data_i;
      end
      if (cfg_idx_i == rmm_pkg::REG_RANGE_HIGH) begin
        range_hi_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cyc_q       <= '0;
      op_q        <= OP_D_DN;
      cnt_q       <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      m3_q        <= '0;
      m4_q        <= '0;
      min_q       <= '0;
      max_q       <= '0;
      any_q       <= 1'b0;
      sat_q       <= 1'b0;
      oor_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_fire && !done_go) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (smp_fire) begin
            state_q <= ST_DIV;
            cyc_q   <= '0;
          end
        end
        ST_DIV: begin
          cyc_q <= cyc_q + 6'd1;
          if (cyc_q == 6'(DW - 1)) begin
            state_q <= ST_SGN;
          end
        end
        ST_SGN: begin
          state_q <= ST_LOAD;
          op_q    <= OP_D_DN;
        end
        ST_LOAD: begin
          state_q <= ST_MUL;
          cyc_q   <= '0;
        end
        ST_MUL: begin
          cyc_q <= cyc_q + 6'd1;
          if (cyc_q[1:0] == 2'd3) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (op_q == OP_F) begin
            state_q <= ST_ADD;
            cyc_q   <= '0;
          end else begin
            op_q    <= op_q + 4'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_ADD: begin
          cyc_q <= cyc_q + 6'd1;
          if (cyc_q[0]) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
            cnt_q       <= n_q;
            mean_q      <= mean_sum[MW-1:0];
            m2_q        <= m2_new;
            m3_q        <= ab_q;
            m4_q        <= m4_new;
            min_q       <= min_new;
            max_q       <= max_new;
            any_q       <= 1'b1;
            oor_q       <= oor_pend_q;
            sat_q       <= sat_q | sat_hit_q | m4_sat | m2_sat;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; their contents only matter within one sample.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (smp_fire) begin
          x_q        <= smp_i.sample;
          oor_pend_q <= oor_new;
          d_q        <= d_new;
          dneg_q     <= d_new[DW-1];
          quo_q      <= d_mag;
          rem_q      <= '0;
          n_q        <= (cnt_q < CNT_MAX) ? (cnt_q + CW'(1)) : cnt_q;
          sat_hit_q  <= (cnt_q == CNT_MAX);
        end
      end
      ST_DIV: begin
        rem_q <= rem_ge ? CW'(rem_sh - {1'b0, n_q}) : rem_sh[CW-1:0];
        quo_q <= {quo_q[DW-2:0], rem_ge};
      end
      ST_SGN: begin
        dn_q <= dneg_q ? (~{{(W-DW){1'b0}}, quo_q} + W'(1)) : {{(W-DW){1'b0}}, quo_q};
      end
      ST_LOAD: begin
        ma_q  <= opa[W-1] ? (~opa + W'(1)) : opa;
        mb_q  <= opb[W-1] ? (~opb + W'(1)) : opb;
        neg_q <= opa[W-1] ^ opb[W-1];
        sh_q  <= sh_sel;
        acc_q <= '0;
      end
      ST_MUL: begin
        acc_q <= acc_q + pterm;
      end
      ST_FIN: begin
        sat_hit_q <= sat_hit_q | over;
        case (op_q)
          OP_T1:   t1_q  <= mres;
          OP_DN2:  dn2_q <= mres;
          OP_A:    a_q   <= mres;
          OP_B:    b_q   <= mres;
          OP_K:    k_q   <= mres;
          OP_C:    c_q   <= mres;
          OP_E:    e_q   <= mres;
          OP_F:    f_q   <= mres;
          default: p_q   <= mres;
        endcase
      end
      ST_ADD: begin
        if (!cyc_q[0]) begin
          ab_q      <= ab_r[W-1:0];
          ce_q      <= ce_r[W-1:0];
          sat_hit_q <= sat_hit_q | ab_r[W] | ce_r[W];
        end else begin
          // The new M3 is parked in ab_q; the old M3 is still needed above.
          ab_q      <= m3_r[W-1:0];
          inc4_q    <= inc4_r[W-1:0];
          sat_hit_q <= sat_hit_q | m3_r[W] | inc4_r[W];
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.count         = cnt_q;
  assign res_o.mean          = mean_q;
  assign res_o.sum_sq_dev    = m2_q;
  assign res_o.sum_cube_dev  = m3_q;
  assign res_o.sum_quart_dev = m4_q;
  assign res_o.sample_min    = min_q;
  assign res_o.sample_max    = max_q;
  assign res_o.out_of_range  = oor_q;
  assign res_o.saturated     = sat_q;

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |=> sat_q)
    else $error("saturation flag cleared");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> ($stable(cnt_q) && $stable(m4_q) && $stable(mean_q)))
    else $error("statistics changed while a result was pending");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q >= $past(cnt_q)))
    else $error("count decreased");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_fire |=> (state_q == ST_DIV && cyc_q == 6'd0))
    else $error("accepted sample did not start the division");

endmodule

// ----- dv/tb_running_moments_minmax_core.sv -----
module tb_running_moments_minmax_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS    = rmm_pkg::SAMPLE_BITS;
  localparam int COUNT_BITS     = rmm_pkg::COUNT_BITS;
  localparam int MEAN_FRAC_BITS = rmm_pkg::MEAN_FRAC_BITS;
  localparam int MEAN_BITS      = rmm_pkg::MEAN_BITS;
  localparam int M2_BITS        = rmm_pkg::M2_BITS;
  localparam int M2_FRAC_BITS   = rmm_pkg::M2_FRAC_BITS;
  localparam int M4_MID_BITS    = rmm_pkg::M4_MID_BITS;
  localparam int ACC_BITS       = rmm_pkg::ACC_BITS;
  localparam int CFG_IDX_BITS   = rmm_pkg::CFG_IDX_BITS;

  localparam int N_RANDOM = 1730;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         count;
    logic signed [MEAN_BITS-1:0]   mean;
    logic [M2_BITS-1:0]            sum_sq_dev;
    logic signed [ACC_BITS-1:0]    sum_cube_dev;
    logic [ACC_BITS-1:0]           sum_quart_dev;
    logic signed [SAMPLE_BITS-1:0] sample_min;
    logic signed [SAMPLE_BITS-1:0] sample_max;
    logic                          out_of_range;
    logic                          saturated;
  } stats_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [CFG_IDX_BITS-1:0]       idx;
    logic signed [SAMPLE_BITS-1:0] value;
    stats_t                        typed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = rmm_pkg::REG_RANGE_LOW;
  logic [SAMPLE_BITS-1:0] cfg_data_i = '0;

  rmm_smp_if smp ();
  rmm_res_if res ();

  running_moments_minmax_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_i     (smp),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic signed [SAMPLE_BITS-1:0] lim_low, lim_high;
  longint unsigned n_seen;
  longint          mean_q, m3_q;
  longint unsigned m2_q, m4_q;
  logic signed [SAMPLE_BITS-1:0] lo_seen, hi_seen;
  bit first_done, sticky_sat, clamp_hit;

  stats_t expected_stats[$];
  int n_mismatch = 0;
  int n_checked = 0;
  int n_oor = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;

  // trunc(a*b / 2^s) toward zero, clamped to the 64-bit signed range.
  function automatic longint mul_shift(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0]  ua, ub, lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {64'b0, ua} * {64'b0, ub};
    p   = p >> s;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (p > {64'b0, lim}) begin
      clamp_hit = 1'b1;
      p = {64'b0, lim};
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    logic signed [64:0] r;
    r = a;
    r = r + b;
    if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      clamp_hit = 1'b1;
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    if (r < -65'sh0_8000_0000_0000_0000) begin
      clamp_hit = 1'b1;
      return 64'h8000_0000_0000_0000;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic longint clamp_diff(longint a, longint b);
    logic signed [64:0] r;
    r = a;
    r = r - b;
    if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      clamp_hit = 1'b1;
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    if (r < -65'sh0_8000_0000_0000_0000) begin
      clamp_hit = 1'b1;
      return 64'h8000_0000_0000_0000;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic void reset_stats();
    lim_low = rmm_pkg::RANGE_LOW_RST;
    lim_high = rmm_pkg::RANGE_HIGH_RST;
    n_seen = 0; mean_q = 0; m2_q = 0; m3_q = 0; m4_q = 0;
    lo_seen = '0; hi_seen = '0;
    first_done = 0; sticky_sat = 0;
  endfunction

  function automatic stats_t update_stats(logic signed [SAMPLE_BITS-1:0] x);
    stats_t r;
    longint n, d, dn, dn2, t1, m2o, m3o, a, b, c, e, f, inc4;
    logic [63:0] mag;
    clamp_hit = 1'b0;
    r.out_of_range = (x < lim_low) || (x > lim_high);
    if (!first_done) begin
      lo_seen = x; hi_seen = x; first_done = 1;
    end else begin
      if (x > hi_seen) hi_seen = x;
      if (x < lo_seen) lo_seen = x;
    end
    if (n_seen < 65535) n_seen++;
    else clamp_hit = 1'b1;
    n = longint'(n_seen);

    d   = (longint'(x) <<< MEAN_FRAC_BITS) - mean_q;
    dn  = d / n;
    dn2 = mul_shift(dn, dn, MEAN_FRAC_BITS);
    t1  = mul_shift(mul_shift(d, dn, MEAN_FRAC_BITS), n - 1, 0);
    m2o = longint'(m2_q);
    m3o = m3_q;

    a = mul_shift(mul_shift(t1, dn, MEAN_FRAC_BITS), n - 2, MEAN_FRAC_BITS);
    b = mul_shift(mul_shift(dn, m2o, MEAN_FRAC_BITS + M2_FRAC_BITS), 3, 0);
    m3_q = clamp_sum(m3o, clamp_diff(a, b));

    c = mul_shift(mul_shift(t1, dn2, 2 * MEAN_FRAC_BITS - M4_MID_BITS),
                  n * n - 3 * n + 3, M4_MID_BITS);
    e = mul_shift(mul_shift(dn2, m2o, MEAN_FRAC_BITS + M2_FRAC_BITS), 6, 0);
    f = mul_shift(mul_shift(dn, m3o, MEAN_FRAC_BITS), 4, 0);
    inc4 = clamp_diff(clamp_sum(c, e), f);
    if (inc4 >= 0) begin
      if (m4_q > 64'hFFFF_FFFF_FFFF_FFFF - 64'(inc4)) begin
        m4_q = 64'hFFFF_FFFF_FFFF_FFFF;
        clamp_hit = 1'b1;
      end else begin
        m4_q = m4_q + 64'(inc4);
      end
    end else begin
      mag = 64'(-inc4);
      m4_q = (mag > m4_q) ? 64'd0 : m4_q - mag;
    end

    m2_q = m2_q + 64'(t1 / (longint'(1) <<< (MEAN_FRAC_BITS - M2_FRAC_BITS)));
    if (m2_q > 64'h0000_FFFF_FFFF_FFFF) begin
      m2_q = 64'h0000_FFFF_FFFF_FFFF;
      clamp_hit = 1'b1;
    end
    mean_q = mean_q + dn;
    if (clamp_hit) sticky_sat = 1;

    r.count = n_seen[COUNT_BITS-1:0];
    r.mean = mean_q[MEAN_BITS-1:0];
    r.sum_sq_dev = m2_q[M2_BITS-1:0];
    r.sum_cube_dev = m3_q;
    r.sum_quart_dev = m4_q;
    r.sample_min = lo_seen;
    r.sample_max = hi_seen;
    r.saturated = sticky_sat;
    return r;
  endfunction

  task automatic wait_idle();
    wait (expected_stats.size() == 0);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic signed [SAMPLE_BITS-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rmm_pkg::REG_RANGE_LOW) lim_low = v;
    else lim_high = v;
  endtask

  task automatic set_range(logic signed [SAMPLE_BITS-1:0] lo, logic signed [SAMPLE_BITS-1:0] hi);
    wait_idle();
    write_reg(rmm_pkg::REG_RANGE_LOW, lo);
    write_reg(rmm_pkg::REG_RANGE_HIGH, hi);
  endtask

  // Offers one sample and returns at the edge where the transaction happens.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, bit typed, stats_t typed_res);
    stats_t p;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.sample <= x;
    do @(posedge clk_i); while (!smp.ready);
    p = update_stats(x);
    if (p.out_of_range) n_oor++;
    expected_stats.insert(expected_stats.size(), typed ? typed_res : p);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return ($urandom_range(0, 1) != 0) ? 12'sh7FF : 12'sh800;
    if (k < 30) return lim_low + $signed(12'($urandom_range(0, 4) - 2));
    if (k < 45) return lim_high + $signed(12'($urandom_range(0, 4) - 2));
    if (k < 70) return $signed(12'($urandom_range(0, 200) - 100));
    return $signed(12'($urandom_range(0, 4095)));
  endfunction

  // Result side: compare each transaction, then choose the next ready level.
  always @(posedge clk_i) begin
    stats_t want, got;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.count, res.mean, res.sum_sq_dev, res.sum_cube_dev, res.sum_quart_dev,
              res.sample_min, res.sample_max, res.out_of_range, res.saturated};
      n_checked++;
      if (expected_stats.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result %0d mismatch", n_checked);
            $display("  expected cnt=%0d mean=%h m2=%h m3=%h m4=%h min=%0d max=%0d oor=%b sat=%b",
                     want.count, want.mean, want.sum_sq_dev, want.sum_cube_dev,
                     want.sum_quart_dev, want.sample_min, want.sample_max,
                     want.out_of_range, want.saturated);
            $display("  actual   cnt=%0d mean=%h m2=%h m3=%h m4=%h min=%0d max=%0d oor=%b sat=%b",
                     got.count, got.mean, got.sum_sq_dev, got.sum_cube_dev,
                     got.sum_quart_dev, got.sample_min, got.sample_max,
                     got.out_of_range, got.saturated);
          end
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  row_t plan[$];

  function automatic void add_row(row_kind_e k, logic [CFG_IDX_BITS-1:0] i,
                                  logic signed [SAMPLE_BITS-1:0] v);
    row_t r;
    r.kind = k; r.idx = i; r.value = v; r.typed = '0;
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    stats_t first_res;
    int phase;
    smp.valid = 1'b0;
    smp.sample = '0;
    reset_stats();

    // The first sample after reset: the mean is the sample itself, no spread.
    first_res = '{16'd1, 32'sh8000_0000, 48'd0, 64'sd0, 64'd0,
                  12'sh800, 12'sh800, 1'b0, 1'b0};
    add_row(ROW_TYPED, rmm_pkg::REG_RANGE_LOW, 12'sh800);
    plan[0].typed = first_res;
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh7FF);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh000);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, -12'sd1);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sd1);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh7FF);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh800);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh555);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'shAAA);
    // Narrow range: samples just past both bounds are flagged but still counted; samples at the bounds are not flagged.
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_LOW, -12'sd5);
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_HIGH, 12'sd5);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, -12'sd6);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, -12'sd5);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sd5);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sd6);
    // Inverted range flags every sample.
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_LOW, 12'sd10);
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_HIGH, -12'sd10);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sd0);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh7FF);
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_LOW, 12'sh800);
    add_row(ROW_CFG, rmm_pkg::REG_RANGE_HIGH, 12'sh7FF);
    add_row(ROW_SAMPLE, rmm_pkg::REG_RANGE_LOW, 12'sh800);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        smp.valid <= 1'b0;
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].value, plan[i].kind == ROW_TYPED, plan[i].typed);
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 350 == 0) begin
        phase = i / 350;
        smp.valid <= 1'b0;
        case (phase)
          0: begin set_range(12'sh800, 12'sh7FF); tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1: begin set_range(-12'sd100, 12'sd100); tx_idle_pct = 60; rx_stall_pct = 0; end
          2: begin set_range(12'sd0, 12'sd0);     tx_idle_pct = 0;  rx_stall_pct = 60; end
          3: begin set_range(12'sh7FF, 12'sh800); tx_idle_pct = 15; rx_stall_pct = 15; end
          default: begin set_range(12'sd500, -12'sd500); tx_idle_pct = 0; rx_stall_pct = 0; end
        endcase
      end
      // A long receiver hold-off while samples keep coming fills the block.
      if (i == 100) rx_hold = 800;
      // Drain everything once in the middle of a phase.
      if (i == 200) begin
        smp.valid <= 1'b0;
        wait (expected_stats.size() == 0);
        @(posedge clk_i);
      end
      send_sample(pick_sample(), 1'b0, '0);
    end
    smp.valid <= 1'b0;

    wait (expected_stats.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d result transactions over %0d range settings, %0d samples flagged.",
             n_checked, 5 + 3, n_oor);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching transactions", n_mismatch);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d results outstanding", expected_stats.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
